### rtl/trail_fade_strip_renderer_top_defines.svh
// Assertion macros for the checker file tfsr_checker.sv.
`ifndef TRAIL_FADE_STRIP_RENDERER_TOP_DEFINES_SVH
`define TRAIL_FADE_STRIP_RENDERER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TFSR_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define TFSR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tfsr_pkg.sv
package tfsr_pkg;

  localparam int TRAIL_LENGTH_DEF  = 64;
  localparam int STRIP_COLUMNS_DEF = 8;

  localparam int X_W      = 9;
  localparam int Y_W      = 8;
  localparam int OFFSET_W = 3;
  localparam int COLOR_W  = 16;
  localparam int SEL_W    = 2;
  localparam int LIMIT_W  = 8;
  localparam int CFG_W    = 8;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  localparam logic [SEL_W-1:0] SEL_RED   = 2'd0;
  localparam logic [SEL_W-1:0] SEL_GREEN = 2'd1;
  localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd2;

  localparam logic REG_COLOR  = 1'b0;
  localparam logic REG_REPEAT = 1'b1;

  localparam logic [LIMIT_W-1:0] REPEAT_LIMIT_RST = 8'd16;
  localparam logic [LIMIT_W-1:0] REPEAT_SAT       = 8'hFF;

  localparam int CH5_MAX = 'h1F;
  localparam int CH6_MAX = 'h3F;

  typedef struct packed {
    logic                hit;
    logic [OFFSET_W-1:0] line_offset;
    logic [Y_W-1:0]      row;
    logic [COLOR_W-1:0]  pixel_color;
    logic                last;
  } res_t;

  typedef struct packed {
    logic cand_valid;
    logic flush;
  } emit_ctl_t;

  typedef struct packed {
    logic stall;
    logic flush_done;
  } emit_sts_t;

endpackage

### rtl/tfsr_store.sv
module tfsr_store #(
  parameter int TRAIL_LENGTH = tfsr_pkg::TRAIL_LENGTH_DEF,
  parameter int PW           = $clog2(tfsr_pkg::TRAIL_LENGTH_DEF)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [PW-1:0]          wr_addr,
  input  logic [tfsr_pkg::X_W-1:0] wr_x,
  input  logic [tfsr_pkg::Y_W-1:0] wr_y,
  input  logic                   rd_en,
  input  logic [PW-1:0]          rd_addr,
  output logic [tfsr_pkg::X_W-1:0] rd_x,
  output logic [tfsr_pkg::Y_W-1:0] rd_y,
  output logic                   rd_valid
);
  import tfsr_pkg::*;

  logic [X_W+Y_W-1:0] mem [TRAIL_LENGTH];
  logic [TRAIL_LENGTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_y, wr_x};
    end
    if (rd_en) begin
      {rd_y, rd_x} <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

endmodule

### rtl/tfsr_shade.sv
module tfsr_shade #(
  parameter int TRAIL_LENGTH  = tfsr_pkg::TRAIL_LENGTH_DEF,
  parameter int STRIP_COLUMNS = tfsr_pkg::STRIP_COLUMNS_DEF,
  parameter int PW            = $clog2(tfsr_pkg::TRAIL_LENGTH_DEF)
) (
  input  logic                       entry_valid,
  input  logic [tfsr_pkg::X_W-1:0]   entry_x,
  input  logic [tfsr_pkg::Y_W-1:0]   entry_y,
  input  logic [PW-1:0]              entry_idx,
  input  logic [PW-1:0]              write_pointer,
  input  logic [tfsr_pkg::X_W-1:0]   strip_start,
  input  logic [tfsr_pkg::SEL_W-1:0] color_select,
  output logic                       hit,
  output tfsr_pkg::res_t             res
);
  import tfsr_pkg::*;

  logic [4:0] ch5_tbl [TRAIL_LENGTH];
  logic [5:0] ch6_tbl [TRAIL_LENGTH];

  for (genvar g = 0; g < TRAIL_LENGTH; g++) begin : g_fade
    localparam int C5 = (CH5_MAX * (TRAIL_LENGTH - g)) / TRAIL_LENGTH;
    localparam int C6 = (CH6_MAX * (TRAIL_LENGTH - g)) / TRAIL_LENGTH;
    assign ch5_tbl[g] = 5'(C5);
    assign ch6_tbl[g] = 6'(C6);
  end

  logic [X_W:0]     strip_end;
  logic [X_W-1:0]   offset_full;
  logic [PW:0]      age_raw;
  logic [PW-1:0]    age;
  logic [4:0]       lvl5;
  logic [5:0]       lvl6;
  logic [COLOR_W-1:0] color;

  // age = (write_pointer - idx - 1) mod TRAIL_LENGTH
  always_comb begin
    strip_end   = {1'b0, strip_start} + (X_W+1)'(STRIP_COLUMNS);
    hit         = entry_valid && (entry_x >= strip_start) && ({1'b0, entry_x} < strip_end);
    offset_full = entry_x - strip_start;
    age_raw     = {1'b0, write_pointer} + (PW+1)'(TRAIL_LENGTH - 1) - {1'b0, entry_idx};
    if (age_raw >= (PW+1)'(TRAIL_LENGTH)) begin
      age_raw = age_raw - (PW+1)'(TRAIL_LENGTH);
    end
    age  = age_raw[PW-1:0];
    lvl5 = ch5_tbl[age];
    lvl6 = ch6_tbl[age];
    unique case (color_select)
      SEL_RED:   color = {lvl5, 11'b0};
      SEL_GREEN: color = {5'b0, lvl6, 5'b0};
      SEL_BLUE:  color = {11'b0, lvl5};
      default:   color = '0;
    endcase
    res.hit         = 1'b1;
    res.line_offset = offset_full[OFFSET_W-1:0];
    res.row         = entry_y;
    res.pixel_color = color;
    res.last        = 1'b0;
  end

endmodule

### rtl/tfsr_emit.sv
module tfsr_emit (
  input  logic                clk,
  input  logic                rst,
  input  tfsr_pkg::emit_ctl_t ctl,
  input  tfsr_pkg::res_t      cand,
  input  logic                out_ready,
  output tfsr_pkg::emit_sts_t sts,
  output logic                out_valid,
  output tfsr_pkg::res_t      out_res
);
  import tfsr_pkg::*;

  // one hit is held back until the next one shows whether it is the last
  logic pend_valid;
  res_t pend_res;
  res_t flush_res;
  logic out_free;
  logic push_pend;
  logic load_pend;
  logic do_flush;

  always_comb begin
    out_free       = !out_valid || out_ready;
    push_pend      = ctl.cand_valid && pend_valid && out_free;
    load_pend      = ctl.cand_valid && (!pend_valid || out_free);
    do_flush       = ctl.flush && out_free;
    sts.stall      = ctl.cand_valid && pend_valid && !out_free;
    sts.flush_done = do_flush;
    if (pend_valid) begin
      flush_res = pend_res;
    end else begin
      flush_res = '0;
    end
    flush_res.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (push_pend || do_flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_flush) begin
        pend_valid <= 1'b0;
      end else if (load_pend) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_pend) begin
      out_res <= pend_res;
    end else if (do_flush) begin
      out_res <= flush_res;
    end
    if (load_pend) begin
      pend_res <= cand;
    end
  end

endmodule

### rtl/trail_fade_strip_renderer_top.sv
// Trail fade strip renderer.
// Input channel s_*: one item per handshake. s_tuser selects the function:
// add a point (point_x, point_y) or render the column strip at strip_start.
// Output channel m_*: render results only. m_tuser is the hit flag, m_tlast
// marks the final result of a render; a render with no match returns one
// non-hit item with zero data and tlast set.
// Adds give no result. A render walks all TRAIL_LENGTH entries of the point
// memory, one read per cycle while the output does not stall; s_tready is
// low meanwhile. A held hit is registered onto m_* when the next matching
// entry's read data reaches the emitter; the final result is registered in
// the flush state, after the last entry is read.
// One hit is held until the next is found, so the last one can be marked.
// If m_tready stays low the walk pauses; nothing is dropped.
// Reset (rst, synchronous) invalidates all entries, clears the write
// pointer, the last point and the repeat count, and sets color_select to
// red and repeat_limit to 16. Config writes (cfg_we) belong in idle time.
module trail_fade_strip_renderer_top #(
  parameter int TRAIL_LENGTH  = tfsr_pkg::TRAIL_LENGTH_DEF,
  parameter int STRIP_COLUMNS = tfsr_pkg::STRIP_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // point_x[8:0], point_y[16:9], strip_start[25:17], zero
  input  logic        s_tuser,  // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // line_offset[2:0], row[10:3], pixel_color[26:11], zero
  output logic        m_tuser,  // hit
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [tfsr_pkg::CFG_W-1:0] cfg_data
);
  import tfsr_pkg::*;

  localparam int PW = $clog2(TRAIL_LENGTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state;

  logic [SEL_W-1:0]   color_select;
  logic [LIMIT_W-1:0] repeat_limit;
  logic [PW-1:0]      write_pointer;
  logic [X_W-1:0]     last_x;
  logic [Y_W-1:0]     last_y;
  logic               last_valid;
  logic [LIMIT_W-1:0] repeat_count;
  logic [X_W-1:0]     strip_start;
  logic [PW-1:0]      scan_idx;
  logic               issuing;
  logic               s1_valid;
  logic [PW-1:0]      s1_idx;
  logic               s1_end;

  logic [X_W-1:0] in_x;
  logic [Y_W-1:0] in_y;
  logic [X_W-1:0] in_start;
  logic           accept;
  logic           add_store;
  logic           wr_en;
  logic           issue;
  logic           stall;
  logic [X_W-1:0] rd_x;
  logic [Y_W-1:0] rd_y;
  logic           rd_valid;
  logic           shade_hit;
  res_t           shade_res;
  emit_ctl_t      emit_ctl;
  emit_sts_t      emit_sts;
  res_t           out_res;

  assign in_x     = s_tdata[8:0];
  assign in_y     = s_tdata[16:9];
  assign in_start = s_tdata[25:17];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    add_store = !last_valid || (last_x != in_x) || (last_y != in_y) ||
                (repeat_count >= repeat_limit);
    wr_en     = accept && (s_tuser == FUNC_ADD) && add_store;
    stall     = emit_sts.stall;
    issue     = (state == ST_SCAN) && issuing && !stall;
    emit_ctl.cand_valid = s1_valid && shade_hit;
    emit_ctl.flush      = (state == ST_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      color_select  <= SEL_RED;
      repeat_limit  <= REPEAT_LIMIT_RST;
      write_pointer <= '0;
      last_valid    <= 1'b0;
      repeat_count  <= '0;
      issuing       <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COLOR:  color_select <= cfg_data[SEL_W-1:0];
          REG_REPEAT: repeat_limit <= cfg_data[LIMIT_W-1:0];
          default:    ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && s_tuser == FUNC_ADD) begin
            if (add_store) begin
              last_valid    <= 1'b1;
              repeat_count  <= '0;
              write_pointer <= (write_pointer == PW'(TRAIL_LENGTH - 1)) ? '0
                               : write_pointer + 1'b1;
            end else if (repeat_count != REPEAT_SAT) begin
              repeat_count <= repeat_count + 1'b1;
            end
          end else if (accept) begin
            state   <= ST_SCAN;
            issuing <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            s1_valid <= issue;
            if (issue && scan_idx == PW'(TRAIL_LENGTH - 1)) begin
              issuing <= 1'b0;
            end
            if (s1_valid && s1_end) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (emit_sts.flush_done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_x <= in_x;
      last_y <= in_y;
    end
    if (accept && s_tuser == FUNC_RENDER) begin
      strip_start <= in_start;
      scan_idx    <= '0;
    end else if (issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (issue) begin
      s1_idx <= scan_idx;
      s1_end <= (scan_idx == PW'(TRAIL_LENGTH - 1));
    end
  end

  tfsr_store #(
    .TRAIL_LENGTH (TRAIL_LENGTH),
    .PW           (PW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (write_pointer),
    .wr_x     (in_x),
    .wr_y     (in_y),
    .rd_en    (issue),
    .rd_addr  (scan_idx),
    .rd_x     (rd_x),
    .rd_y     (rd_y),
    .rd_valid (rd_valid)
  );

  tfsr_shade #(
    .TRAIL_LENGTH  (TRAIL_LENGTH),
    .STRIP_COLUMNS (STRIP_COLUMNS),
    .PW            (PW)
  ) u_shade (
    .entry_valid   (rd_valid),
    .entry_x       (rd_x),
    .entry_y       (rd_y),
    .entry_idx     (s1_idx),
    .write_pointer (write_pointer),
    .strip_start   (strip_start),
    .color_select  (color_select),
    .hit           (shade_hit),
    .res           (shade_res)
  );

  tfsr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctl       (emit_ctl),
    .cand      (shade_res),
    .out_ready (m_tready),
    .sts       (emit_sts),
    .out_valid (m_tvalid),
    .out_res   (out_res)
  );

  assign m_tdata = {5'b0, out_res.pixel_color, out_res.row, out_res.line_offset};
  assign m_tuser = out_res.hit;
  assign m_tlast = out_res.last;

endmodule

### rtl/tfsr_checker.sv
`include "trail_fade_strip_renderer_top_defines.svh"

module tfsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  import tfsr_pkg::*;

  logic in_accept;

  assign in_accept = s_tvalid && s_tready;

  `TFSR_ASSERT_IMPLY(a_miss_is_last, m_tvalid && !m_tuser, m_tlast, "miss without tlast")
  `TFSR_ASSERT_IMPLY(a_miss_is_zero, m_tvalid && !m_tuser, m_tdata == 32'd0, "miss with data")
  `TFSR_ASSERT_NEXT(a_render_busy, in_accept && s_tuser == FUNC_RENDER, !s_tready, "render not busy")
  `TFSR_ASSERT_NEXT(a_add_one_cycle, in_accept && s_tuser == FUNC_ADD, s_tready, "add stalled")
  `TFSR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result item dropped")

endmodule

bind trail_fade_strip_renderer_top tfsr_checker u_tfsr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### verif/tb_trail_fade_strip_renderer_top.sv
module tb_trail_fade_strip_renderer_top;
  import tfsr_pkg::*;

  localparam int TRAIL = TRAIL_LENGTH_DEF;
  localparam int STRIP = STRIP_COLUMNS_DEF;
  localparam int SETTLE_CYCLES = TRAIL_LENGTH_DEF + 16;
  localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic s_tuser = FUNC_ADD;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_COLOR;
  logic [CFG_W-1:0] cfg_data = '0;

  trail_fade_strip_renderer_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the point ring and registers
  logic [X_W-1:0] trail_x [TRAIL];
  logic [Y_W-1:0] trail_y [TRAIL];
  logic trail_v [TRAIL];
  int wr_ptr;
  logic [X_W-1:0] newest_x;
  logic [Y_W-1:0] newest_y;
  logic newest_v;
  logic [LIMIT_W-1:0] repeat_cnt;
  logic [LIMIT_W-1:0] repeat_lim;
  logic [SEL_W-1:0] channel;

  res_t expected_pixels[$];
  int mismatches = 0;
  int tx_idle_pct = 21;
  int rx_idle_pct = 21;
  int rx_hold_left = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [COLOR_W-1:0] faded_color(int age);
    int scale;
    scale = TRAIL - age;
    case (channel)
      SEL_RED: return COLOR_W'((CH5_MAX * scale / TRAIL) << 11);
      SEL_GREEN: return COLOR_W'((CH6_MAX * scale / TRAIL) << 5);
      SEL_BLUE: return COLOR_W'(CH5_MAX * scale / TRAIL);
      default: return '0;
    endcase
  endfunction

  task automatic predict_item(logic func, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                              logic [X_W-1:0] start);
    res_t r;
    int hits;
    int age;
    if (func == FUNC_ADD) begin
      if (!newest_v || newest_x != x || newest_y != y || repeat_cnt >= repeat_lim) begin
        newest_x = x;
        newest_y = y;
        newest_v = 1'b1;
        repeat_cnt = '0;
        trail_x[wr_ptr] = x;
        trail_y[wr_ptr] = y;
        trail_v[wr_ptr] = 1'b1;
        wr_ptr = (wr_ptr + 1) % TRAIL;
      end else if (repeat_cnt != REPEAT_SAT) begin
        repeat_cnt++;
      end
    end else begin
      hits = 0;
      for (int i = 0; i < TRAIL; i++) begin
        if (trail_v[i] && int'(trail_x[i]) >= int'(start) &&
            int'(trail_x[i]) < int'(start) + STRIP) begin
          age = (wr_ptr + 2 * TRAIL - i - 1) % TRAIL;
          r.hit = 1'b1;
          r.line_offset = OFFSET_W'(trail_x[i] - start);
          r.row = trail_y[i];
          r.pixel_color = faded_color(age);
          r.last = 1'b0;
          expected_pixels.push_back(r);
          hits++;
        end
      end
      if (hits == 0) begin
        r = '0;
      end else begin
        r = expected_pixels.pop_back();
      end
      r.last = 1'b1;
      expected_pixels.push_back(r);
    end
  endtask

  task automatic send_item(logic func, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                           logic [X_W-1:0] start);
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {6'd0, start, y, x};
    do @(posedge clk); while (!s_tready);
    predict_item(func, x, y, start);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic add_point(int x, int y);
    send_item(FUNC_ADD, X_W'(x), Y_W'(y), X_W'($urandom));
  endtask

  task automatic render_strip(int start);
    send_item(FUNC_RENDER, X_W'($urandom), Y_W'($urandom), X_W'(start));
  endtask

  // stop sending, let every result come back, then let any add settle
  task automatic drain_trail();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COLOR) channel = val[SEL_W-1:0];
    else repeat_lim = val;
    @(posedge clk);
  endtask

  task automatic test_strip_edges();
    render_strip(511);
    add_point(0, 0);
    add_point(7, 255);
    add_point(8, 128);
    add_point(511, 255);
    add_point(504, 1);
    add_point(503, 2);
    add_point(503, 2);
    add_point(503, 2);
    render_strip(0);
    render_strip(504);
    render_strip(511);
    render_strip(508);
    render_strip(1);
  endtask

  // overfill the ring so the write pointer wraps and every entry hits the strip at 100
  task automatic test_ring_wrap();
    for (int i = 0; i < TRAIL + 6; i++) add_point(100 + i % STRIP, i * 3);
    render_strip(100);
    render_strip(96);
  endtask

  task automatic test_channels();
    logic [SEL_W-1:0] sels [4];
    sels = '{SEL_RED, SEL_GREEN, SEL_BLUE, SEL_NONE};
    foreach (sels[k]) begin
      drain_trail();
      write_reg(REG_COLOR, CFG_W'(sels[k]));
      render_strip(100);
      render_strip(504);
    end
    drain_trail();
    write_reg(REG_COLOR, CFG_W'(SEL_RED));
  endtask

  task automatic test_repeat_limits();
    int lims [4];
    lims = '{0, 1, 40, 16};
    foreach (lims[k]) begin
      drain_trail();
      write_reg(REG_REPEAT, CFG_W'(lims[k]));
      for (int n = 0; n < lims[k] + 3; n++) add_point(300 + k, 10 + k);
      render_strip(300);
    end
  endtask

  task automatic test_backpressure();
    drain_trail();
    rx_hold_left = 400;
    for (int i = 0; i < 10; i++) begin
      add_point(200 + i, i);
      render_strip(198);
    end
    drain_trail();
  endtask

  task automatic test_random_phase(int items, logic [SEL_W-1:0] sel,
                                   logic [LIMIT_W-1:0] lim);
    int hot;
    int pick;
    drain_trail();
    write_reg(REG_COLOR, CFG_W'(sel));
    write_reg(REG_REPEAT, lim);
    hot = $urandom_range(511);
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0) hot = $urandom_range(511);
      if (pick < 15 && newest_v) add_point(newest_x, newest_y);
      else if (pick < 55) add_point(hot + $urandom_range(11), $urandom);
      else if (pick < 65) add_point($urandom, $urandom);
      else if (pick < 90) render_strip(hot - $urandom_range(6));
      else render_strip($urandom);
    end
  endtask

  function automatic void report_pixel(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp h=%0d o=%0d r=%0d c=%h l=%0d, got h=%0d o=%0d r=%0d c=%h l=%0d",
               $time, what, want.hit, want.line_offset, want.row, want.pixel_color, want.last,
               got.hit, got.line_offset, got.row, got.pixel_color, got.last);
  endfunction

  always @(posedge clk) begin : check_pixels
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.hit = m_tuser;
      got.line_offset = m_tdata[2:0];
      got.row = m_tdata[10:3];
      got.pixel_color = m_tdata[26:11];
      got.last = m_tlast;
      if (expected_pixels.size() == 0) begin
        report_pixel("unexpected item", '0, got);
      end else begin
        want = expected_pixels.pop_front();
        if (got.hit !== want.hit || got.line_offset !== want.line_offset ||
            got.row !== want.row || got.pixel_color !== want.pixel_color ||
            got.last !== want.last)
          report_pixel("mismatch", want, got);
      end
    end
  end

  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        m_tready <= 1'b0;
        rx_hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    for (int i = 0; i < TRAIL; i++) begin
      trail_x[i] = '0;
      trail_y[i] = '0;
      trail_v[i] = 1'b0;
    end
    wr_ptr = 0;
    newest_x = '0;
    newest_y = '0;
    newest_v = 1'b0;
    repeat_cnt = '0;
    repeat_lim = REPEAT_LIMIT_RST;
    channel = SEL_RED;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_strip_edges();
    test_ring_wrap();
    test_channels();
    test_repeat_limits();
    test_backpressure();
    test_random_phase(55, SEL_GREEN, 8'd0);
    test_random_phase(55, SEL_BLUE, 8'd255);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_phase(55, SEL_RED, LIMIT_W'($urandom_range(2, 20)));
    tx_idle_pct = 21;
    rx_idle_pct = 21;
    test_random_phase(55, SEL_W'($urandom_range(2)), LIMIT_W'($urandom_range(4)));
    drain_trail();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/tfsr_pkg.sv
rtl/tfsr_store.sv
rtl/tfsr_shade.sv
rtl/tfsr_emit.sv
rtl/trail_fade_strip_renderer_top.sv
rtl/tfsr_checker.sv
verif/tb_trail_fade_strip_renderer_top.sv
